### hdl/cpc_pkg.sv
`default_nettype none

package cpc_pkg;

	// Field widths of the pixel stream, the registers and the result.
	localparam int PIX_W   = 8;
	localparam int DIM_W   = 11;
	localparam int THR_W   = 8;
	localparam int COUNT_W = 21;

	// Line buffer word: the pixel value above its pending contrast flag.
	localparam int LB_DW = PIX_W + 1;

	// Default frame limits, handed to the top level as parameter defaults.
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	// Register port: three 32-bit registers at byte addresses 0, 4 and 8.
	localparam int APB_AW  = 4;
	localparam int APB_DW  = 32;
	localparam int REG_IW  = 2;

	localparam logic [REG_IW-1:0] REG_IMAGE_WIDTH        = 2'd0;
	localparam logic [REG_IW-1:0] REG_IMAGE_HEIGHT       = 2'd1;
	localparam logic [REG_IW-1:0] REG_CONTRAST_THRESHOLD = 2'd2;

	localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST        = 11'd320;
	localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST       = 11'd200;
	localparam logic [THR_W-1:0] CONTRAST_THRESHOLD_RST = 8'd128;

	typedef struct packed {
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
		logic [THR_W-1:0] contrast_threshold;
	} cfg_t;

endpackage

`default_nettype wire

### hdl/cpc_regs.sv
`default_nettype none

module cpc_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [cpc_pkg::APB_AW-1:0]   paddr,
	input  wire logic [cpc_pkg::APB_DW-1:0]   pwdata,
	output logic      [cpc_pkg::APB_DW-1:0]   prdata,
	output logic                              pready,
	output cpc_pkg::cfg_t                     cfg
);

	cpc_pkg::cfg_t                  cfg_q;
	logic [cpc_pkg::REG_IW-1:0]     reg_idx;
	logic                           wr_en;

	assign reg_idx = paddr[cpc_pkg::APB_AW-1:2];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width        <= cpc_pkg::IMAGE_WIDTH_RST;
			cfg_q.image_height       <= cpc_pkg::IMAGE_HEIGHT_RST;
			cfg_q.contrast_threshold <= cpc_pkg::CONTRAST_THRESHOLD_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				cpc_pkg::REG_IMAGE_WIDTH: begin
					cfg_q.image_width <= pwdata[cpc_pkg::DIM_W-1:0];
				end
				cpc_pkg::REG_IMAGE_HEIGHT: begin
					cfg_q.image_height <= pwdata[cpc_pkg::DIM_W-1:0];
				end
				cpc_pkg::REG_CONTRAST_THRESHOLD: begin
					cfg_q.contrast_threshold <= pwdata[cpc_pkg::THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			cpc_pkg::REG_IMAGE_WIDTH: begin
				prdata = cpc_pkg::APB_DW'(cfg_q.image_width);
			end
			cpc_pkg::REG_IMAGE_HEIGHT: begin
				prdata = cpc_pkg::APB_DW'(cfg_q.image_height);
			end
			cpc_pkg::REG_CONTRAST_THRESHOLD: begin
				prdata = cpc_pkg::APB_DW'(cfg_q.contrast_threshold);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

### hdl/cpc_line_buf.sv
`default_nettype none

module cpc_line_buf #(
	parameter int DEPTH = cpc_pkg::MAX_WIDTH_DEF,
	parameter int AW    = $clog2(cpc_pkg::MAX_WIDTH_DEF)
) (
	input  wire logic                        clk,
	input  wire logic                        rd_en,
	input  wire logic [AW-1:0]               rd_addr,
	output logic      [cpc_pkg::LB_DW-1:0]   rd_data,
	input  wire logic                        wr_en,
	input  wire logic [AW-1:0]               wr_addr,
	input  wire logic [cpc_pkg::LB_DW-1:0]   wr_data
);

	logic [cpc_pkg::LB_DW-1:0] mem [DEPTH];
	logic [cpc_pkg::LB_DW-1:0] rd_data_q;

	assign rd_data = rd_data_q;

	// Read before write: a read of the entry being written returns the old word.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### hdl/cpc_pipe.sv
`default_nettype none

module cpc_pipe #(
	parameter int MAX_WIDTH  = cpc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = cpc_pkg::MAX_HEIGHT_DEF,
	parameter int CW         = $clog2(cpc_pkg::MAX_WIDTH_DEF)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cpc_pkg::cfg_t                 cfg,
	input  wire logic                          pixel_valid,
	output logic                               pixel_ready,
	input  wire logic [cpc_pkg::PIX_W-1:0]     pixel_value,
	output logic                               count_valid,
	input  wire logic                          count_ready,
	output logic      [cpc_pkg::COUNT_W-1:0]   contrast_count,
	output logic                               lb_rd_en,
	output logic      [CW-1:0]                 lb_rd_addr,
	input  wire logic [cpc_pkg::LB_DW-1:0]     lb_rd_data,
	output logic                               lb_wr_en,
	output logic      [CW-1:0]                 lb_wr_addr,
	output logic      [cpc_pkg::LB_DW-1:0]     lb_wr_data
);

	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int CWX  = (CW + 1 > cpc_pkg::DIM_W) ? CW + 1 : cpc_pkg::DIM_W;
	localparam int RWX  = (RW + 1 > cpc_pkg::DIM_W) ? RW + 1 : cpc_pkg::DIM_W;
	localparam int PW   = cpc_pkg::PIX_W;
	localparam int NW   = cpc_pkg::COUNT_W;

	function automatic logic differs(input logic [PW-1:0] a, input logic [PW-1:0] b,
			input logic [cpc_pkg::THR_W-1:0] thr);
		logic [PW-1:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return d > thr;
	endfunction

	// Scan position of the next item.
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          accept;
	logic          last_col_s0;
	logic          last_row_s0;

	// Compare stage.
	logic                        valid_s1;
	logic [PW-1:0]               value_s1;
	logic [CW-1:0]               col_s1;
	logic                        row_nz_s1;
	logic                        last_col_s1;
	logic                        last_row_s1;
	logic                        fwd_v_s1;
	logic [cpc_pkg::LB_DW-1:0]   fwd_data_s1;

	logic [PW-1:0]               held_value_q;
	logic                        held_flag_q;
	logic [NW-1:0]               count_q;
	logic                        pend_v_q;
	logic [CW-1:0]               pend_addr_q;
	logic [cpc_pkg::LB_DW-1:0]   pend_data_q;
	logic                        out_v_q;
	logic [NW-1:0]               out_count_q;

	logic [cpc_pkg::LB_DW-1:0]   above;
	logic                        col_nz;
	logic                        upd;
	logic                        lfd;
	logic                        left_flag;
	logic                        cur;
	logic                        add_up;
	logic                        add_left;
	logic                        add_cur;
	logic [NW:0]                 sum;
	logic [NW-1:0]               count_sat;
	logic                        emit;
	logic                        s1_go;
	logic                        left_wr;
	logic                        new_pend;
	logic [cpc_pkg::LB_DW-1:0]   cur_word;

	assign accept = pixel_valid & pixel_ready;

	assign last_col_s0 = ((CWX'(col_q) + CWX'(1)) >= CWX'(cfg.image_width))
		|| (col_q == CW'(MAX_WIDTH - 1));
	assign last_row_s0 = ((RWX'(row_q) + RWX'(1)) >= RWX'(cfg.image_height))
		|| (row_q == RW'(MAX_HEIGHT - 1));

	// Compare stage logic.
	assign above     = fwd_v_s1 ? fwd_data_s1 : lb_rd_data;
	assign col_nz    = (col_s1 != '0);
	assign upd       = row_nz_s1 & differs(value_s1, above[PW:1], cfg.contrast_threshold);
	assign lfd       = col_nz & differs(value_s1, held_value_q, cfg.contrast_threshold);
	assign left_flag = held_flag_q | lfd;
	assign cur       = upd | lfd;
	assign cur_word  = {value_s1, cur};

	assign add_up   = row_nz_s1 & (above[0] | upd);
	assign add_left = col_nz & last_row_s1 & left_flag;
	assign add_cur  = last_col_s1 & last_row_s1 & cur;
	assign sum      = {1'b0, count_q} + (NW + 1)'(add_up) + (NW + 1)'(add_left)
		+ (NW + 1)'(add_cur);
	assign count_sat = sum[NW] ? '1 : sum[NW-1:0];

	assign emit        = last_col_s1 & last_row_s1;
	assign s1_go       = valid_s1 & (~emit | ~out_v_q | count_ready);
	assign pixel_ready = ~valid_s1 | s1_go;

	// Write port: the finished left neighbour, or the row's last entry in the cycle after its compare.
	assign left_wr    = s1_go & col_nz;
	assign new_pend   = s1_go & last_col_s1;
	assign lb_wr_en   = left_wr | pend_v_q;
	assign lb_wr_addr = left_wr ? (col_s1 - CW'(1)) : pend_addr_q;
	assign lb_wr_data = left_wr ? {held_value_q, left_flag} : pend_data_q;

	assign lb_rd_en   = accept;
	assign lb_rd_addr = col_q;

	assign count_valid    = out_v_q;
	assign contrast_count = out_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			valid_s1     <= 1'b0;
			held_value_q <= '0;
			held_flag_q  <= 1'b0;
			count_q      <= '0;
			pend_v_q     <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			if (accept) begin
				if (last_col_s0) begin
					col_q <= '0;
					row_q <= last_row_s0 ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (pixel_ready) begin
				valid_s1 <= pixel_valid;
			end
			if (s1_go) begin
				if (last_col_s1) begin
					held_value_q <= '0;
					held_flag_q  <= 1'b0;
				end else begin
					held_value_q <= value_s1;
					held_flag_q  <= cur;
				end
				count_q <= emit ? '0 : count_sat;
			end
			pend_v_q <= new_pend;
			if (s1_go && emit) begin
				out_v_q <= 1'b1;
			end else if (count_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload registers; the forward check covers the writes still in flight.
	always_ff @(posedge clk) begin
		if (accept) begin
			value_s1    <= pixel_value;
			col_s1      <= col_q;
			row_nz_s1   <= (row_q != '0);
			last_col_s1 <= last_col_s0;
			last_row_s1 <= last_row_s0;
			if (new_pend && (col_s1 == col_q)) begin
				fwd_v_s1    <= 1'b1;
				fwd_data_s1 <= cur_word;
			end else if (lb_wr_en && (lb_wr_addr == col_q)) begin
				fwd_v_s1    <= 1'b1;
				fwd_data_s1 <= lb_wr_data;
			end else begin
				fwd_v_s1    <= 1'b0;
				fwd_data_s1 <= lb_wr_data;
			end
		end
		if (new_pend) begin
			pend_addr_q <= col_s1;
			pend_data_q <= cur_word;
		end
		if (s1_go && emit) begin
			out_count_q <= count_sat;
		end
	end

endmodule

`default_nettype wire

### hdl/contrast_pixel_counter.sv
// Contrast pixel counter. Grey pixels of 8 bits arrive in raster order, one
// item per clock, for a frame of image_width by image_height pixels (each
// clamped to 1..MAX_WIDTH and 1..MAX_HEIGHT). A pixel counts as contrast
// when it differs by more than contrast_threshold from at least one 4-neighbour
// that exists in the frame; edge and corner pixels check every neighbour they
// have. After the last pixel of a frame one item carrying the count (saturating
// at 2^21-1) is offered, and the next frame starts at once. Throughput is one
// pixel per clock while the count output is not held: each item passes two
// stages, a read of the line buffer and then the compare, count and write-back,
// and the count item is registered as the frame's last pixel leaves the compare
// stage. The line buffer is a single memory of MAX_WIDTH words with one read
// and one write port; a pixel's flag is written back when its right-hand
// neighbour arrives, and the last pixel of a row is written in the cycle after
// its compare, with forwarding to cover reads that overtake these writes. The
// line buffer needs no clearing after reset. Pixel intake stops only when a
// count item is due while the previous one still waits to be taken. The user
// is to write configuration through the register port while the block is idle;
// the block does not enforce this. Registers sit at byte addresses 0, 4 and 8.
`default_nettype none

module contrast_pixel_counter #(
	parameter int MAX_WIDTH  = cpc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = cpc_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [cpc_pkg::APB_AW-1:0]    paddr,
	input  wire logic [cpc_pkg::APB_DW-1:0]    pwdata,
	output logic      [cpc_pkg::APB_DW-1:0]    prdata,
	output logic                               pready,
	input  wire logic                          pixel_valid,
	output logic                               pixel_ready,
	input  wire logic [cpc_pkg::PIX_W-1:0]     pixel_value,
	output logic                               count_valid,
	input  wire logic                          count_ready,
	output logic      [cpc_pkg::COUNT_W-1:0]   contrast_count
);

	// Column index width; the row counter width is worked out in the pipeline.
	localparam int CW = $clog2(MAX_WIDTH);

	cpc_pkg::cfg_t               cfg;
	logic                        lb_rd_en;
	logic [CW-1:0]               lb_rd_addr;
	logic [cpc_pkg::LB_DW-1:0]   lb_rd_data;
	logic                        lb_wr_en;
	logic [CW-1:0]               lb_wr_addr;
	logic [cpc_pkg::LB_DW-1:0]   lb_wr_data;

	// Frame size and threshold registers.
	cpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Previous row: each word holds a pixel value and its pending contrast flag.
	cpc_line_buf #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (lb_rd_en),
		.rd_addr (lb_rd_addr),
		.rd_data (lb_rd_data),
		.wr_en   (lb_wr_en),
		.wr_addr (lb_wr_addr),
		.wr_data (lb_wr_data)
	);

	// Scan position, neighbour compare, counting and the count output register.
	cpc_pipe #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.CW         (CW)
	) u_pipe (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.pixel_valid    (pixel_valid),
		.pixel_ready    (pixel_ready),
		.pixel_value    (pixel_value),
		.count_valid    (count_valid),
		.count_ready    (count_ready),
		.contrast_count (contrast_count),
		.lb_rd_en       (lb_rd_en),
		.lb_rd_addr     (lb_rd_addr),
		.lb_rd_data     (lb_rd_data),
		.lb_wr_en       (lb_wr_en),
		.lb_wr_addr     (lb_wr_addr),
		.lb_wr_data     (lb_wr_data)
	);

endmodule

`default_nettype wire
